/* design/ami_pkg.sv */
// ----------------------------------------------------------------------------
// ami_pkg
// Shared widths, index codes, cofactor tables and item structs for the
// affine matrix inverse core.
// ----------------------------------------------------------------------------
package ami_pkg;

  localparam int EW = 32;
  localparam int NW = 64;
  localparam int DW = 98;
  localparam int RW = 132;
  localparam int QB = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FLOOR_W = 16;

  localparam logic [3:0] IDX_Z0  = 4'd3;
  localparam logic [3:0] IDX_Z1  = 4'd7;
  localparam logic [3:0] IDX_Z2  = 4'd11;
  localparam logic [3:0] IDX_T0  = 4'd12;
  localparam logic [3:0] IDX_ONE = 4'd15;

  localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

  // cofactor k = m[CF_A]*m[CF_B] - m[CF_C]*m[CF_D], m in input order
  localparam int CF_A [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CF_B [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CF_C [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int CF_D [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  // determinant and translation products: m[PM] * n[PN]
  localparam int PM [12] = '{0, 3, 6, 9, 10, 11, 9, 10, 11, 9, 10, 11};
  localparam int PN [12] = '{0, 1, 2, 0, 3, 6, 1, 4, 7, 2, 5, 8};

  typedef struct packed {
    logic [3:0]          idx;
    logic                is_const;
    logic [EW-1:0]       cval;
    logic                singular;
    logic                last;
    logic                tr;
    logic signed [DW-1:0] x;
    logic [DW-1:0]       dabs;
    logic                dneg;
  } issue_t;

  typedef struct packed {
    logic [3:0]    idx;
    logic          is_const;
    logic [EW-1:0] cval;
    logic          singular;
    logic          last;
    logic          neg;
    logic          sat;
    logic [QB-1:0] q;
    logic [RW-1:0] rem;
    logic [RW-1:0] d2;
  } job_t;

endpackage

/* design/affine_matrix_inverse_core.sv */
// ----------------------------------------------------------------------------
// affine_matrix_inverse_core
// Inverse of a column-major 4x4 affine matrix in signed fixed point.
// Sixteen elements per matrix, or a single element if singular, follow on
// consecutive cycles through the one-element-per-cycle result port. busy
// rises while the element issuer is still draining the previous matrix.
// Synchronous reset clears all valid bits and sets det_floor to 0; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
module affine_matrix_inverse_core #(
  parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [ami_pkg::EW-1:0]  in_0,
  input  logic signed [ami_pkg::EW-1:0]  in_1,
  input  logic signed [ami_pkg::EW-1:0]  in_2,
  input  logic signed [ami_pkg::EW-1:0]  in_4,
  input  logic signed [ami_pkg::EW-1:0]  in_5,
  input  logic signed [ami_pkg::EW-1:0]  in_6,
  input  logic signed [ami_pkg::EW-1:0]  in_8,
  input  logic signed [ami_pkg::EW-1:0]  in_9,
  input  logic signed [ami_pkg::EW-1:0]  in_10,
  input  logic signed [ami_pkg::EW-1:0]  in_12,
  input  logic signed [ami_pkg::EW-1:0]  in_13,
  input  logic signed [ami_pkg::EW-1:0]  in_14,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ami_pkg::FLOOR_W-1:0]    cfg_det_floor,
  output logic                           out_strobe,
  output logic [3:0]                     out_elem_index,
  output logic signed [ami_pkg::EW-1:0]  out_elem_value,
  output logic                           out_singular,
  output logic                           out_last
);

  localparam int DW = ami_pkg::DW;

  logic [ami_pkg::FLOOR_W-1:0]   floor_r;

  logic                          en;
  logic                          stall;
  logic                          can_load;
  logic                          last_now;

  logic                          s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic signed [ami_pkg::EW-1:0] s1_m_r [12];
  logic signed [ami_pkg::EW-1:0] s2_m_r [12];
  logic signed [ami_pkg::EW-1:0] s3_m_r [12];
  logic signed [ami_pkg::NW-1:0] s2_pa_r [9];
  logic signed [ami_pkg::NW-1:0] s2_pb_r [9];
  logic signed [ami_pkg::NW-1:0] s3_n_r [9];
  logic signed [ami_pkg::NW-1:0] s4_n_r [9];
  logic signed [ami_pkg::NW-1:0] s5_n_r [9];
  logic signed [ami_pkg::NW-1:0] s6_n_r [9];
  logic signed [ami_pkg::NW-1:0] s7_n_r [9];
  logic signed [ami_pkg::NW:0]   s4_lo_r [12];
  logic signed [ami_pkg::NW-1:0] s4_hi_r [12];
  logic signed [DW-1:0]          s5_p_r [12];
  logic signed [DW-1:0]          s6_det_r;
  logic signed [DW-1:0]          s6_tn_r [3];
  logic signed [DW-1:0]          s7_tn_r [3];
  logic [DW-1:0]                 s7_dabs_r;
  logic                          s7_dneg_r;
  logic                          s7_sing_r;
  logic [DW-1:0]                 dabs_nxt;

  logic                          act_r;
  logic [3:0]                    cnt_r;
  logic signed [ami_pkg::NW-1:0] is_n_r [9];
  logic signed [DW-1:0]          is_tn_r [3];
  logic [DW-1:0]                 is_dabs_r;
  logic                          is_dneg_r;
  logic                          is_sing_r;

  logic [3:0]                    nsel;
  logic [1:0]                    tsel;
  ami_pkg::issue_t               iss;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      floor_r <= cfg_det_floor;
    end
  end

  assign last_now = is_sing_r || (cnt_r == ami_pkg::IDX_ONE);
  assign can_load = !act_r || last_now;
  assign stall    = s7_v_r && !can_load;
  assign en       = !stall;
  assign busy     = stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= start;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_comb begin
    dabs_nxt = s6_det_r[DW-1] ? DW'(-s6_det_r) : DW'(s6_det_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m_r <= '{in_0, in_1, in_2, in_4, in_5, in_6, in_8, in_9, in_10,
                  in_12, in_13, in_14};
      // cofactor partial products
      for (int k = 0; k < 9; k++) begin
        s2_pa_r[k] <= s1_m_r[ami_pkg::CF_A[k]] * s1_m_r[ami_pkg::CF_B[k]];
        s2_pb_r[k] <= s1_m_r[ami_pkg::CF_C[k]] * s1_m_r[ami_pkg::CF_D[k]];
      end
      s2_m_r <= s1_m_r;
      for (int k = 0; k < 9; k++) begin
        s3_n_r[k] <= s2_pa_r[k] - s2_pb_r[k];
      end
      s3_m_r <= s2_m_r;
      // split 32x64 products into halves
      for (int j = 0; j < 12; j++) begin
        s4_lo_r[j] <= s3_m_r[ami_pkg::PM[j]] *
                      $signed({1'b0, s3_n_r[ami_pkg::PN[j]][31:0]});
        s4_hi_r[j] <= s3_m_r[ami_pkg::PM[j]] * $signed(s3_n_r[ami_pkg::PN[j]][63:32]);
      end
      s4_n_r <= s3_n_r;
      for (int j = 0; j < 12; j++) begin
        s5_p_r[j] <= (DW'(s4_hi_r[j]) <<< 32) + DW'(s4_lo_r[j]);
      end
      s5_n_r <= s4_n_r;
      s6_det_r <= s5_p_r[0] + s5_p_r[1] + s5_p_r[2];
      for (int k = 0; k < 3; k++) begin
        s6_tn_r[k] <= -(s5_p_r[3*k+3] + s5_p_r[3*k+4] + s5_p_r[3*k+5]);
      end
      s6_n_r    <= s5_n_r;
      s7_dabs_r <= dabs_nxt;
      s7_dneg_r <= s6_det_r[DW-1];
      s7_sing_r <= dabs_nxt <= (DW'(floor_r) << (2 * FRAC_BITS));
      s7_tn_r   <= s6_tn_r;
      s7_n_r    <= s6_n_r;
    end
  end

  // element issuer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (s7_v_r && can_load) begin
      act_r <= 1'b1;
      cnt_r <= '0;
    end else if (act_r && last_now) begin
      act_r <= 1'b0;
    end else if (act_r) begin
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s7_v_r && can_load) begin
      is_n_r    <= s7_n_r;
      is_tn_r   <= s7_tn_r;
      is_dabs_r <= s7_dabs_r;
      is_dneg_r <= s7_dneg_r;
      is_sing_r <= s7_sing_r;
    end
  end

  always_comb begin
    nsel = 4'(cnt_r[3:2]) * 4'd3 + 4'(cnt_r[1:0]);
    if (nsel > 4'd8) begin
      nsel = '0;
    end
    tsel = cnt_r[1:0];
    if (tsel == 2'd3) begin
      tsel = '0;
    end
    iss.idx      = is_sing_r ? 4'd0 : cnt_r;
    iss.is_const = is_sing_r || (cnt_r inside {ami_pkg::IDX_Z0, ami_pkg::IDX_Z1,
                                               ami_pkg::IDX_Z2, ami_pkg::IDX_ONE});
    iss.cval     = (!is_sing_r && cnt_r == ami_pkg::IDX_ONE) ?
                   (ami_pkg::EW'(1) << FRAC_BITS) : '0;
    iss.singular = is_sing_r;
    iss.last     = last_now;
    iss.tr       = cnt_r >= ami_pkg::IDX_T0;
    iss.x        = iss.tr ? is_tn_r[tsel] : DW'(is_n_r[nsel]);
    iss.dabs     = is_dabs_r;
    iss.dneg     = is_dneg_r;
  end

  ami_div_pipe #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .iss_valid  (act_r),
    .iss        (iss),
    .o_valid    (out_strobe),
    .o_idx      (out_elem_index),
    .o_value    (out_elem_value),
    .o_singular (out_singular),
    .o_last     (out_last)
  );

endmodule

/* design/ami_div_pipe.sv */
// ----------------------------------------------------------------------------
// ami_div_pipe
// Pipelined restoring divider: one quotient bit per stage, rounding to
// nearest with halves away from zero, sign and 32-bit saturation.
// ----------------------------------------------------------------------------
module ami_div_pipe #(
  parameter int FRAC_BITS = ami_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      iss_valid,
  input  ami_pkg::issue_t           iss,
  output logic                      o_valid,
  output logic [3:0]                o_idx,
  output logic [ami_pkg::EW-1:0]    o_value,
  output logic                      o_singular,
  output logic                      o_last
);

  localparam int NS = ami_pkg::QB + 2;

  logic                         xneg;
  logic [ami_pkg::DW-1:0]       xmag;
  logic [ami_pkg::RW-1:0]       shifted;
  ami_pkg::job_t                st_r   [NS];
  ami_pkg::job_t                st_nxt [NS];
  logic [NS-1:0]                v_r;
  logic [ami_pkg::EW-1:0]       val_nxt;
  logic                         o_valid_r;
  logic [3:0]                   o_idx_r;
  logic [ami_pkg::EW-1:0]       o_value_r;
  logic                         o_singular_r;
  logic                         o_last_r;

  always_comb begin
    xneg = iss.x[ami_pkg::DW-1];
    xmag = xneg ? ami_pkg::DW'(-iss.x) : ami_pkg::DW'(iss.x);
    if (iss.tr) begin
      shifted = ami_pkg::RW'(xmag) << (FRAC_BITS + 1);
    end else begin
      shifted = ami_pkg::RW'(xmag) << (2 * FRAC_BITS + 1);
    end
    st_nxt[0].idx      = iss.idx;
    st_nxt[0].is_const = iss.is_const;
    st_nxt[0].cval     = iss.cval;
    st_nxt[0].singular = iss.singular;
    st_nxt[0].last     = iss.last;
    st_nxt[0].neg      = xneg ^ iss.dneg;
    st_nxt[0].sat      = 1'b0;
    st_nxt[0].q        = '0;
    st_nxt[0].rem      = shifted + ami_pkg::RW'(iss.dabs);
    st_nxt[0].d2       = ami_pkg::RW'(iss.dabs) << 1;

    st_nxt[1]     = st_r[0];
    st_nxt[1].sat = st_r[0].rem >= (st_r[0].d2 << ami_pkg::QB);

    for (int k = 0; k < ami_pkg::QB; k++) begin
      st_nxt[k+2] = st_r[k+1];
      if (!st_r[k+1].sat && st_r[k+1].rem >= (st_r[k+1].d2 << (ami_pkg::QB - 1 - k))) begin
        st_nxt[k+2].rem = st_r[k+1].rem - (st_r[k+1].d2 << (ami_pkg::QB - 1 - k));
        st_nxt[k+2].q[ami_pkg::QB-1-k] = 1'b1;
      end
    end

    if (st_r[NS-1].is_const) begin
      val_nxt = st_r[NS-1].cval;
    end else if (!st_r[NS-1].neg) begin
      val_nxt = (st_r[NS-1].sat || st_r[NS-1].q[ami_pkg::QB-1]) ?
                ami_pkg::SAT_POS : st_r[NS-1].q;
    end else begin
      val_nxt = (st_r[NS-1].sat || st_r[NS-1].q > ami_pkg::SAT_NEG) ?
                ami_pkg::SAT_NEG : ami_pkg::EW'(-st_r[NS-1].q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= '0;
      o_valid_r <= 1'b0;
    end else begin
      v_r       <= {v_r[NS-2:0], iss_valid};
      o_valid_r <= v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      st_r[s] <= st_nxt[s];
    end
    o_idx_r      <= st_r[NS-1].idx;
    o_value_r    <= val_nxt;
    o_singular_r <= st_r[NS-1].singular;
    o_last_r     <= st_r[NS-1].last;
  end

  assign o_valid    = o_valid_r;
  assign o_idx      = o_idx_r;
  assign o_value    = o_value_r;
  assign o_singular = o_singular_r;
  assign o_last     = o_last_r;

endmodule

/* verif/tb_affine_matrix_inverse_core.sv */
// ----------------------------------------------------------------------------
// tb_affine_matrix_inverse_core
// Self-checking bench for the affine matrix inverse core. Matrices go in
// through the start/busy port. An exact wide-integer predictor builds the
// expected element stream: singular test against det_floor, rounded
// quotients and saturation. Each strobed element is checked against it.
// The run covers directed corner matrices, several floor settings and
// random matrices under varying sender idling.
// ----------------------------------------------------------------------------
module tb_affine_matrix_inverse_core;

  localparam int FB = ami_pkg::FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [ami_pkg::EW-1:0] elem_t;

  typedef struct {
    logic [3:0] idx;
    elem_t      value;
    logic       singular;
    logic       last;
  } inv_elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  elem_t mat_in [12];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ami_pkg::FLOOR_W-1:0] cfg_det_floor = '0;
  logic out_strobe;
  logic [3:0] out_elem_index;
  elem_t out_elem_value;
  logic out_singular;
  logic out_last;

  inv_elem_t inv_queue[$];
  logic [ami_pkg::FLOOR_W-1:0] floor_model = '0;
  int errors = 0;
  int stall_cycles = 0;
  int idle_pct = 0;

  initial begin
    for (int i = 0; i < 12; i++) mat_in[i] = '0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  affine_matrix_inverse_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_0(mat_in[0]), .in_1(mat_in[1]), .in_2(mat_in[2]),
    .in_4(mat_in[3]), .in_5(mat_in[4]), .in_6(mat_in[5]),
    .in_8(mat_in[6]), .in_9(mat_in[7]), .in_10(mat_in[8]),
    .in_12(mat_in[9]), .in_13(mat_in[10]), .in_14(mat_in[11]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_det_floor(cfg_det_floor),
    .out_strobe(out_strobe), .out_elem_index(out_elem_index),
    .out_elem_value(out_elem_value), .out_singular(out_singular),
    .out_last(out_last)
  );

  function automatic elem_t round_quot(wide_t num, int sh, wide_t den);
    logic neg;
    wide_t dmag, nmag, q, nq;
    neg = (num < 0) != (den < 0);
    dmag = (den < 0) ? -den : den;
    nmag = (num < 0) ? -num : num;
    q = ((nmag <<< (sh + 1)) + dmag) / (dmag <<< 1);
    if (!neg) begin
      if (q > wide_t'(64'h7FFF_FFFF)) return ami_pkg::SAT_POS;
      return q[ami_pkg::EW-1:0];
    end
    if (q > wide_t'(64'h8000_0000)) return ami_pkg::SAT_NEG;
    nq = -q;
    return nq[ami_pkg::EW-1:0];
  endfunction

  task automatic predict_inverse(input elem_t a [12]);
    wide_t m [16];
    wide_t cof [16];
    wide_t det, tn;
    inv_elem_t e;
    int k;
    for (int i = 0; i < 16; i++) begin
      m[i] = '0;
      cof[i] = '0;
    end
    m[0] = wide_t'(a[0]); m[1] = wide_t'(a[1]); m[2] = wide_t'(a[2]);
    m[4] = wide_t'(a[3]); m[5] = wide_t'(a[4]); m[6] = wide_t'(a[5]);
    m[8] = wide_t'(a[6]); m[9] = wide_t'(a[7]); m[10] = wide_t'(a[8]);
    m[12] = wide_t'(a[9]); m[13] = wide_t'(a[10]); m[14] = wide_t'(a[11]);
    cof[0] = m[5] * m[10] - m[9] * m[6];
    cof[1] = m[9] * m[2] - m[1] * m[10];
    cof[2] = m[1] * m[6] - m[5] * m[2];
    cof[4] = m[8] * m[6] - m[4] * m[10];
    cof[5] = m[0] * m[10] - m[8] * m[2];
    cof[6] = m[4] * m[2] - m[0] * m[6];
    cof[8] = m[4] * m[9] - m[8] * m[5];
    cof[9] = m[8] * m[1] - m[0] * m[9];
    cof[10] = m[0] * m[5] - m[4] * m[1];
    det = m[0] * cof[0] + m[4] * cof[1] + m[8] * cof[2];
    if (((det < 0) ? -det : det) <= (wide_t'(floor_model) <<< (2 * FB))) begin
      e.idx = '0;
      e.value = '0;
      e.singular = 1'b1;
      e.last = 1'b1;
      inv_queue.push_back(e);
      return;
    end
    for (int i = 0; i < 16; i++) begin
      e.idx = i[3:0];
      e.singular = 1'b0;
      e.last = (e.idx == ami_pkg::IDX_ONE);
      if (e.idx == ami_pkg::IDX_ONE) e.value = elem_t'(1) <<< FB;
      else if (e.idx == ami_pkg::IDX_Z0 || e.idx == ami_pkg::IDX_Z1 ||
               e.idx == ami_pkg::IDX_Z2) e.value = '0;
      else if (e.idx >= ami_pkg::IDX_T0) begin
        k = i - 12;
        tn = -(m[12] * cof[k] + m[13] * cof[4 + k] + m[14] * cof[8 + k]);
        e.value = round_quot(tn, FB, det);
      end else e.value = round_quot(cof[i], 2 * FB, det);
      inv_queue.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("error at %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    inv_elem_t e;
    if (rst_n && out_strobe) begin
      if (inv_queue.size() == 0)
        report_mismatch("unexpected item index", int'(out_elem_index), 0);
      else begin
        e = inv_queue.pop_front();
        if (out_elem_index !== e.idx)
          report_mismatch("elem_index", int'(out_elem_index), int'(e.idx));
        if (out_elem_value !== e.value)
          report_mismatch("elem_value", int'(out_elem_value), int'(e.value));
        if (out_singular !== e.singular)
          report_mismatch("singular", int'(out_singular), int'(e.singular));
        if (out_last !== e.last)
          report_mismatch("last", int'(out_last), int'(e.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic lower_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_matrix(input elem_t a [12]);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      lower_start();
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end else @(negedge clk);
    mat_in = a;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_inverse(a);
  endtask

  task automatic wait_drained();
    lower_start();
    while (inv_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_floor(input logic [ami_pkg::FLOOR_W-1:0] v);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_det_floor = v;
    do @(posedge clk); while (!cfg_ready);
    floor_model = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic elem_t rand_elem(input int span_bits);
    logic [ami_pkg::EW-1:0] r;
    r = $urandom();
    if (span_bits >= ami_pkg::EW) return r;
    return elem_t'($signed(r)) >>> (ami_pkg::EW - span_bits);
  endfunction

  task automatic send_diag(input elem_t d0, input elem_t d1, input elem_t d2,
                           input elem_t tx, input elem_t ty, input elem_t tz);
    elem_t a [12];
    for (int i = 0; i < 12; i++) a[i] = '0;
    a[0] = d0; a[4] = d1; a[8] = d2;
    a[9] = tx; a[10] = ty; a[11] = tz;
    send_matrix(a);
  endtask

  task automatic send_fill(input elem_t v);
    elem_t a [12];
    for (int i = 0; i < 12; i++) a[i] = v;
    send_matrix(a);
  endtask

  task automatic test_directed();
    elem_t a [12];
    send_diag(32'h1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0);
    send_diag(32'h2_0000, 32'h4_0000, -32'sh8000, 32'h3_0000, -32'sh1_8000, 32'h7FFF_FFFF);
    send_diag(0, 0, 0, 32'h1234, 0, 0);
    send_diag(1, 1, 1, 1, -1, 0);
    send_diag(32'h1_0000, 32'h1_0000, 1, 0, 0, 0);
    send_diag(3, 32'h1_0000, 32'h1_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF);
    send_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000);
    send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1);
    send_fill(32'h8000_0000);
    send_fill(32'h7FFF_FFFF);
    send_fill(-1);
    for (int i = 0; i < 12; i++) a[i] = '0;
    a[1] = 32'h1_0000; a[3] = 32'h1_0000; a[8] = -32'sh1_0000;
    a[9] = 32'h5_0000; a[10] = -32'sh2_0000; a[11] = 32'h0_8000;
    send_matrix(a);
    a[0] = 32'h2_0000; a[2] = 32'h1_0000; a[5] = 32'h3_0000; a[7] = 32'h4_0000;
    send_matrix(a);
    send_diag(32'h3_0000, 32'h3_0000, 32'h3_0000, 32'h1_0000, 32'h2_0000, -32'sh1_0000);
    send_diag(32'hFFFF_0001, 2, 32'h7FFF_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
  endtask

  task automatic test_floor_edges();
    write_floor(16'd1);
    send_diag(32'h1_0000, 32'h1_0000, 1, 0, 0, 0);
    send_diag(32'h1_0000, 32'h1_0000, 2, 7, 0, 0);
    write_floor(16'hFFFF);
    send_diag(32'h1_0000, 32'h1_0000, 32'hFFFF, 0, 0, 0);
    send_diag(32'h1_0000, 32'h1_0000, 32'h1_0000, 1, 2, 3);
    send_diag(-32'sh1_0000, 32'h1_0000, 32'h1_0000, 0, 0, 0);
    send_diag(32'h1_0000, 32'h1_0000, -32'sh1_0000, 9, 9, 9);
    send_diag(32'h1_0000, 32'h1_0000, -32'sh1_0001, 9, 9, 9);
    write_floor(16'h8000);
    send_diag(32'h8000, 32'h1_0000, 32'h1_0000, 0, 0, 0);
    send_diag(32'h8001, 32'h1_0000, 32'h1_0000, 0, 0, 0);
  endtask

  task automatic test_random(input int count, input int pct);
    elem_t a [12];
    int shape;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      shape = $urandom_range(9);
      for (int i = 0; i < 12; i++)
        a[i] = (shape < 2) ? rand_elem(ami_pkg::EW) : rand_elem($urandom_range(12, 22));
      if (shape == 2) begin
        for (int i = 0; i < 3; i++) a[6 + i] = a[i] + a[3 + i];
      end else if (shape == 3) begin
        a[8] = a[8] >>> 8;
        a[7] = a[1];
        a[6] = a[0] + 1;
      end else if (shape == 4) begin
        for (int i = 0; i < 9; i++) if ($urandom_range(1) == 1) a[i] = '0;
      end
      send_matrix(a);
      if ($urandom_range(199) == 0) wait_drained();
    end
    idle_pct = 0;
  endtask

  task automatic test_pause_until_empty();
    wait_drained();
    send_diag(32'h4_0000, 32'h1_0000, 32'h0_4000, -32'sh1_0000, 0, 32'h2_0000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_floor_edges();
    write_floor(16'd0);
    test_random(150, 12);
    test_pause_until_empty();
    write_floor(16'($urandom_range(1, 16'hFFFE)));
    test_random(150, 83);
    write_floor(16'hFFFF);
    test_random(60, 0);
    write_floor(16'd0);
    test_random(90, 0);
    wait_drained();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
